/* src/mshs_pkg.sv */
package mshs_pkg;

    localparam int NumSub     = 4;
    localparam int NumBkt     = 16;
    localparam int NumSlot    = 2;
    localparam int SubW       = $clog2(NumSub);
    localparam int PosW       = $clog2(NumBkt);
    localparam int SlotW      = (NumSlot > 1) ? $clog2(NumSlot) : 1;
    localparam int FillW      = $clog2(NumSlot + 1);
    localparam int BktW       = SubW + PosW;
    localparam int KeyAddrW   = BktW + SlotW;
    localparam int KeyDepth   = 1 << KeyAddrW;

    localparam logic [31:0] SeedReset = 32'd42;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    // hash step selector for the shared multiplier
    typedef enum logic [2:0] {
        HS_K1 = 3'd0,
        HS_K2 = 3'd1,
        HS_H5 = 3'd2,
        HS_M1 = 3'd3,
        HS_M2 = 3'd4
    } t_hstep;

endpackage

/* src/mshs_hash.sv */
module mshs_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_key,
    input  logic [31:0] i_seed,
    output logic        o_done,
    output logic [31:0] o_hash
);
    import mshs_pkg::*;

    logic   r_busy, n_busy;
    t_hstep r_step, n_step;
    logic [31:0] r_k, n_k;
    logic [31:0] r_h, n_h;
    logic [31:0] r_seed, n_seed;
    logic        r_done, n_done;
    logic [31:0] mul_a, mul_b, mul_p, h1;

    // one shared 32x32 multiplier, low half kept
    assign mul_p = mul_a * mul_b;

    always_comb begin
        h1 = r_seed ^ r_k;
        mul_a = r_k;
        mul_b = 32'hcc9e2d51;
        unique case (r_step)
            HS_K1: begin mul_a = r_k; mul_b = 32'hcc9e2d51; end
            HS_K2: begin mul_a = {r_k[16:0], r_k[31:17]}; mul_b = 32'h1b873593; end
            HS_H5: begin mul_a = {h1[18:0], h1[31:19]}; mul_b = 32'd5; end
            HS_M1: begin mul_a = r_h ^ {16'd0, r_h[31:16]}; mul_b = 32'h85ebca6b; end
            HS_M2: begin mul_a = r_h ^ {13'd0, r_h[31:13]}; mul_b = 32'hc2b2ae35; end
            default: begin mul_a = r_k; mul_b = 32'hcc9e2d51; end
        endcase
    end

    // step sequencer
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_k    = r_k;
        n_h    = r_h;
        n_seed = r_seed;
        n_done = 1'b0;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_step = HS_K1;
            n_k    = i_key;
            n_seed = i_seed;
        end else if (r_busy) begin
            unique case (r_step)
                HS_K1: begin n_k = mul_p; n_step = HS_K2; end
                HS_K2: begin n_k = mul_p; n_step = HS_H5; end
                HS_H5: begin
                    n_h = (mul_p + 32'he6546b64) ^ 32'd4;
                    n_step = HS_M1;
                end
                HS_M1: begin n_h = mul_p; n_step = HS_M2; end
                HS_M2: begin
                    n_h = mul_p ^ {16'd0, mul_p[31:16]};
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= HS_K1;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_done <= n_done;
        end
        r_k    <= n_k;
        r_h    <= n_h;
        r_seed <= n_seed;
    end

    assign o_done = r_done;
    assign o_hash = r_h;
endmodule

/* src/multi_subtable_hash_set_top.sv */
// flow: an item is hashed first; for insert or an unused command the result strobe
// follows the hash, for lookup it follows the 8 slot reads and the last compare,
// and delete also shifts the later slots down before it
// throughput: one item at a time; busy drops in the strobe cycle, so the next item
// can be taken at the edge that ends it; the receiver cannot stall
// reset: synchronous active low, seed back to 42, all bucket counts cleared
module multi_subtable_hash_set_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_success,
    output logic [1:0]  o_status
);
    import mshs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HASH  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_SWR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_seed;
    logic [1:0]  r_cmd;
    logic [31:0] r_key;
    logic [PosW-1:0] r_pos;
    logic [NumSub-1:0][FillW-1:0] r_fill [NumBkt];
    logic [31:0] r_mem [KeyDepth];
    logic [31:0] r_rd;
    logic [KeyAddrW-1:0] rd_addr;
    logic        wr_en;
    logic [KeyAddrW-1:0] wr_addr;
    logic [31:0] wr_data;

    logic [SubW-1:0]  r_sub;
    logic [SlotW-1:0] r_slot;
    logic             r_rd_pend;
    logic [SubW-1:0]  r_rd_sub;
    logic [SlotW-1:0] r_rd_slot;
    logic             r_found;
    logic [SubW-1:0]  r_hit_sub;
    logic [SlotW-1:0] r_hit_slot;
    logic             r_res_succ;
    logic [1:0]       r_res_stat;
    logic             r_valid;
    logic             hash_done;
    logic [31:0]      hash_val;

    mshs_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && r_state == S_IDLE),
        .i_key   (i_key),
        .i_seed  (r_seed),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    function automatic logic [BktW-1:0] bkt(input logic [SubW-1:0] s,
                                            input logic [PosW-1:0] p);
        bkt = {s, p};
    endfunction

    // insert decision uses the hashed position directly
    logic [PosW-1:0] h_pos;
    logic            ins_have_h;
    logic [SubW-1:0] ins_sub_h;
    logic [FillW-1:0] ins_fill_h;
    assign h_pos = hash_val[PosW-1:0];
    always_comb begin
        logic [FillW-1:0] f;
        ins_have_h = 1'b0;
        ins_sub_h  = '0;
        ins_fill_h = '0;
        for (int s = 0; s < NumSub; s++) begin
            f = r_fill[h_pos][SubW'(s)];
            if (f < FillW'(NumSlot) && (!ins_have_h || f < ins_fill_h)) begin
                ins_have_h = 1'b1;
                ins_sub_h  = SubW'(s);
                ins_fill_h = f;
            end
        end
    end

    logic [FillW-1:0] hit_fill;
    logic [FillW-1:0] cur_fill;
    assign hit_fill = r_fill[r_pos][r_hit_sub];
    assign cur_fill = r_fill[r_pos][r_sub];

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    // sequencer
    always_comb begin
        n_state = r_state;
        rd_addr = {bkt(r_sub, r_pos), r_slot};
        wr_en   = 1'b0;
        wr_addr = {bkt(ins_sub_h, h_pos), SlotW'(ins_fill_h)};
        wr_data = r_key;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_HASH;
            S_HASH:  if (hash_done) begin
                priority if (r_cmd == CMD_INSERT) n_state = S_DONE;
                else if (r_cmd == CMD_NONE) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_sub == SubW'(NumSub - 1) && r_slot == SlotW'(NumSlot - 1))
                    n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (r_rd_pend) n_state = S_CHECK;
                else if (r_found && r_cmd == CMD_DELETE) n_state = S_SHIFT;
                else n_state = S_DONE;
                rd_addr = {bkt(r_hit_sub, r_pos), r_hit_slot + SlotW'(1)};
            end
            S_SHIFT: begin
                rd_addr = {bkt(r_hit_sub, r_pos), r_hit_slot + SlotW'(1)};
                if (FillW'(r_hit_slot) + FillW'(1) >= hit_fill) n_state = S_DONE;
                else n_state = S_SWR;
            end
            S_SWR: begin
                wr_en   = 1'b1;
                wr_addr = {bkt(r_hit_sub, r_pos), r_hit_slot};
                wr_data = r_rd;
                rd_addr = {bkt(r_hit_sub, r_pos), r_hit_slot + SlotW'(2)};
                n_state = S_SHIFT;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_HASH && hash_done && r_cmd == CMD_INSERT && ins_have_h)
            wr_en = 1'b1;
    end

    // key memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    // control and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seed    <= SeedReset;
            r_valid   <= 1'b0;
            r_rd_pend <= 1'b0;
            r_found   <= 1'b0;
            for (int b = 0; b < NumBkt; b++) r_fill[PosW'(b)] <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_DONE);
            if (i_cfg_valid && o_cfg_ready) r_seed <= i_cfg_data;
            if (r_state == S_IDLE && start) begin
                r_cmd <= i_cmd;
                r_key <= i_key;
                r_found <= 1'b0;
            end
            r_rd_pend <= (r_state == S_SCAN) && (FillW'(r_slot) < cur_fill);
            r_rd_sub  <= r_sub;
            r_rd_slot <= r_slot;
            if (r_rd_pend && r_rd == r_key) begin
                if (!r_found || r_rd_sub != r_hit_sub) begin
                    r_found    <= 1'b1;
                    r_hit_sub  <= r_rd_sub;
                    r_hit_slot <= r_rd_slot;
                end
            end
            if (r_state == S_HASH && hash_done) begin
                r_pos  <= h_pos;
                r_sub  <= '0;
                r_slot <= '0;
                if (r_cmd == CMD_INSERT) begin
                    r_res_succ <= ins_have_h;
                    r_res_stat <= ins_have_h ? ST_DONE : ST_FULL;
                    if (ins_have_h)
                        r_fill[h_pos][ins_sub_h] <= ins_fill_h + FillW'(1);
                end else begin
                    r_res_succ <= 1'b0;
                    r_res_stat <= ST_DONE;
                end
            end
            if (r_state == S_SCAN) begin
                if (r_slot == SlotW'(NumSlot - 1)) begin
                    r_slot <= '0;
                    r_sub  <= r_sub + SubW'(1);
                end else begin
                    r_slot <= r_slot + SlotW'(1);
                end
            end
            if (r_state == S_CHECK && !r_rd_pend) begin
                r_res_succ <= r_found;
                r_res_stat <= r_found ? ST_DONE : ST_MISSING;
            end
            if (r_state == S_SHIFT && n_state == S_DONE)
                r_fill[r_pos][r_hit_sub] <= hit_fill - FillW'(1);
            if (r_state == S_SWR) r_hit_slot <= r_hit_slot + SlotW'(1);
        end
    end

    assign o_valid   = r_valid;
    assign o_success = r_res_succ;
    assign o_status  = r_res_stat;
endmodule

/* src/mshs_checker.sv */
module mshs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_success,
    input logic [1:0]  o_status,
    input logic        o_cfg_ready
);
    import mshs_pkg::*;

    // an accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after item");

    // a result only ends a busy period
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // success always reports done
    a_succ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_success) |-> (o_status == ST_DONE)) else $error("bad status");

    // no configuration while working
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("cfg ready while busy");
endmodule

bind multi_subtable_hash_set_top mshs_checker u_chk (.*);

/* tb/sv/multi_subtable_hash_set_top_tb.sv */
`timescale 1ns / 100ps

module multi_subtable_hash_set_top_tb;
    import mshs_pkg::*;

    typedef struct packed {
        logic       success;
        logic [1:0] status;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [31:0] i_key;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic        o_success;
    logic [1:0]  o_status;

    // shadow of the table
    logic [31:0]      seed_q;
    logic [31:0]      keys_q [KeyDepth];
    int unsigned      fill_q [NumSub*NumBkt];
    t_answer          answers_q [$];
    logic [31:0]      stored_keys [$];
    int unsigned      n_fail;
    longint unsigned  n_cycles;
    int unsigned      burst_left;

    multi_subtable_hash_set_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_success   (o_success),
        .o_status    (o_status)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 400000) begin
            $display("multi_subtable_hash_set_top_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] rotl(logic [31:0] v, int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] murmur32(logic [31:0] key, logic [31:0] seed);
        logic [31:0] k;
        logic [31:0] h;
        k = key * 32'hcc9e2d51;
        k = rotl(k, 15);
        k = k * 32'h1b873593;
        h = seed ^ k;
        h = rotl(h, 13);
        h = h * 32'd5 + 32'he6546b64;
        h = h ^ 32'd4;
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // predict the answer and update the shadow table
    function automatic t_answer apply_op(t_cmd cmd, logic [31:0] key);
        int unsigned pos;
        int unsigned b;
        int unsigned best;
        int unsigned best_fill;
        int unsigned hit_sub;
        int unsigned hit_slot;
        bit          have;
        t_answer     a;
        pos  = murmur32(key, seed_q) % NumBkt;
        a    = '0;
        have = 0;
        best = 0;
        best_fill = 0;
        hit_sub = 0;
        hit_slot = 0;
        case (cmd)
            CMD_INSERT: begin
                for (int s = 0; s < NumSub; s++) begin
                    b = s*NumBkt + pos;
                    if (fill_q[b] < NumSlot && (!have || fill_q[b] < best_fill)) begin
                        have = 1;
                        best = s;
                        best_fill = fill_q[b];
                    end
                end
                if (have) begin
                    b = best*NumBkt + pos;
                    keys_q[b*NumSlot + best_fill] = key;
                    fill_q[b] = best_fill + 1;
                    a.success = 1'b1;
                end else begin
                    a.status = ST_FULL;
                end
            end
            CMD_LOOKUP, CMD_DELETE: begin
                for (int s = 0; s < NumSub; s++) begin
                    b = s*NumBkt + pos;
                    for (int j = 0; j < fill_q[b]; j++) begin
                        if (keys_q[b*NumSlot + j] == key) begin
                            have = 1;
                            hit_sub = s;
                            hit_slot = j;
                            break;
                        end
                    end
                end
                if (!have) begin
                    a.status = ST_MISSING;
                end else begin
                    a.success = 1'b1;
                    if (cmd == CMD_DELETE) begin
                        b = hit_sub*NumBkt + pos;
                        for (int j = hit_slot; j + 1 < fill_q[b]; j++)
                            keys_q[b*NumSlot + j] = keys_q[b*NumSlot + j + 1];
                        fill_q[b] = fill_q[b] - 1;
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (answers_q.size() == 0) begin
                $error("unexpected result success=%0d status=%0d", o_success, o_status);
                n_fail++;
            end else begin
                want = answers_q.pop_front();
                if (o_success !== want.success) begin
                    $error("success: expected %0d, got %0d", want.success, o_success);
                    n_fail++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_fail++;
                end
            end
        end
    end

    // send one item, with bursty gaps; start stays high inside a burst
    task automatic send_op(t_cmd cmd, logic [31:0] key);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= cmd;
        i_key <= key;
        // busy is steady between edges, so the next rising edge takes the item
        while (busy) @(negedge i_clk);
        answers_q.push_back(apply_op(cmd, key));
        if (cmd == CMD_INSERT) stored_keys.push_back(key);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (answers_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // seed write while idle
    task automatic write_seed(logic [31:0] seed);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        seed_q = seed;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if (stored_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom;
    endfunction

    task automatic test_directed();
        send_op(CMD_LOOKUP, 32'h0);
        send_op(CMD_DELETE, 32'hffffffff);
        send_op(CMD_INSERT, 32'h0);
        send_op(CMD_INSERT, 32'hffffffff);
        send_op(CMD_INSERT, 32'h0);
        send_op(CMD_LOOKUP, 32'hffffffff);
        send_op(CMD_LOOKUP, 32'h0);
        send_op(CMD_NONE, 32'h0);
        send_op(CMD_NONE, 32'hffffffff);
        // fill one position past capacity with duplicates
        for (int i = 0; i < NumSub*NumSlot + 2; i++)
            send_op(CMD_INSERT, 32'h1234_5678);
        send_op(CMD_DELETE, 32'h1234_5678);
        send_op(CMD_DELETE, 32'h0);
        send_op(CMD_DELETE, 32'h0);
        send_op(CMD_DELETE, 32'h0);
    endtask

    task automatic test_random(int unsigned n);
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0:                c = CMD_NONE;
                1,2,3,4,5,6,7,8:  c = CMD_INSERT;
                9,10,11,12,13:    c = CMD_LOOKUP;
                default:          c = CMD_DELETE;
            endcase
            send_op(c, pick_key());
        end
    endtask

    task automatic test_seeds();
        write_seed(32'h0);
        test_random(450);
        write_seed(32'hffffffff);
        test_random(450);
        write_seed($urandom);
        test_random(450);
        write_seed(SeedReset);
        test_random(450);
    endtask

    initial begin
        n_fail = 0;
        n_cycles = 0;
        burst_left = 0;
        seed_q = SeedReset;
        foreach (fill_q[i]) fill_q[i] = 0;
        foreach (keys_q[i]) keys_q[i] = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_INSERT;
        i_key = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(120);
        test_seeds();
        drain();
        if (n_fail == 0)
            $display("multi_subtable_hash_set_top_tb OK");
        else
            $display("multi_subtable_hash_set_top_tb NOT OK");
        $finish;
    end

endmodule
